// File: hdl/tlpq_pkg.sv
// Shared types, codes and helpers for the three-level priority queue.
`timescale 1ns / 1ps

package tlpq_pkg;

	localparam int DEPTH_DEF   = 16;
	localparam int ID_BITS_DEF = 16;

	localparam int ENTRY_ID_W = 16;
	localparam int CLASS_W    = 2;
	localparam int POSITION_W = 4;
	localparam int OCCUPANCY_W = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [CLASS_W-1:0] CLASS_RED    = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_YELLOW = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_GREEN  = 2'd2;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_REMOVED   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} tlpq_status_t;

	typedef struct packed {
		logic                  op;
		logic [ENTRY_ID_W-1:0] entry_id;
		logic [CLASS_W-1:0]    priority_class;
	} tlpq_in_t;

	typedef struct packed {
		tlpq_status_t           status;
		logic [POSITION_W-1:0]  position;
		logic [OCCUPANCY_W-1:0] occupancy;
	} tlpq_out_t;

	typedef struct packed {
		logic      valid;
		tlpq_out_t result;
	} tlpq_res_t;

	// A new entry goes before a stored one of a worse class; class three is never passed.
	function automatic logic goes_before(input logic [CLASS_W-1:0] stored_cls,
			input logic [CLASS_W-1:0] new_cls);
		return (stored_cls <= CLASS_GREEN) && (new_cls < stored_cls);
	endfunction

endpackage

// File: hdl/tlpq_core.sv
// Table memory and the sequencer that scans, shifts and writes it.
`timescale 1ns / 1ps

module tlpq_core import tlpq_pkg::*; #(
	parameter int DEPTH   = DEPTH_DEF,
	parameter int ID_BITS = ID_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  tlpq_in_t  req_data,
	output tlpq_res_t res,
	input  logic      res_take
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef struct packed {
		logic [CLASS_W-1:0] cls;
		logic [ID_BITS-1:0] id;
	} slot_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_PUT,
		S_DONE
	} state_t;

	slot_t mem [DEPTH];
	slot_t rdata_q;

	state_t             state_q;
	logic               op_q;
	logic [ID_BITS-1:0] id_q;
	logic [CLASS_W-1:0] cls_q;
	logic [CW-1:0]      cnt_q;
	logic [AW-1:0]      rd_q;
	logic               iss_q;
	logic [AW-1:0]      end_q;
	logic               up_q;
	logic [AW-1:0]      pos_q;
	logic               vld_s1;
	logic [AW-1:0]      addr_s1;
	tlpq_out_t          res_q;

	logic [AW-1:0] last_a;
	logic          hit;
	logic          we;
	logic [AW-1:0] wa;
	slot_t         wd;

	assign last_a    = AW'(cnt_q - CW'(1));
	assign hit       = (op_q == OP_INSERT) ? goes_before(rdata_q.cls, cls_q)
			: (rdata_q.id == id_q);
	assign req_ready = (state_q == S_IDLE);
	assign res.valid  = (state_q == S_DONE);
	assign res.result = res_q;

	always_comb begin
		we = 1'b0;
		wa = up_q ? (addr_s1 - AW'(1)) : (addr_s1 + AW'(1));
		wd = rdata_q;
		if (state_q == S_SHIFT && vld_s1) begin
			we = 1'b1;
		end else if (state_q == S_PUT) begin
			we = 1'b1;
			wa = pos_q;
			wd = '{cls: cls_q, id: id_q};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			iss_q   <= 1'b0;
			vld_s1  <= 1'b0;
			rd_q    <= '0;
		end else begin
			vld_s1  <= iss_q;
			addr_s1 <= rd_q;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q  <= req_data.op;
						id_q  <= ID_BITS'(req_data.entry_id);
						cls_q <= req_data.priority_class;
						rd_q  <= '0;
						if (req_data.op == OP_INSERT && cnt_q == CW'(DEPTH)) begin
							res_q   <= '{status: ST_FULL, position: '0,
									occupancy: OCCUPANCY_W'(cnt_q)};
							state_q <= S_DONE;
						end else if (cnt_q == '0) begin
							if (req_data.op == OP_INSERT) begin
								pos_q   <= '0;
								state_q <= S_PUT;
							end else begin
								res_q   <= '{status: ST_NOT_FOUND, position: '0,
										occupancy: OCCUPANCY_W'(cnt_q)};
								state_q <= S_DONE;
							end
						end else begin
							iss_q   <= 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (iss_q) begin
						if (rd_q == last_a) begin
							iss_q <= 1'b0;
						end else begin
							rd_q <= rd_q + AW'(1);
						end
					end
					if (vld_s1 && hit) begin
						pos_q  <= addr_s1;
						vld_s1 <= 1'b0;
						if (op_q == OP_INSERT) begin
							// Move the tail down by one, last entry first.
							rd_q    <= last_a;
							end_q   <= addr_s1;
							up_q    <= 1'b0;
							iss_q   <= 1'b1;
							state_q <= S_SHIFT;
						end else if (addr_s1 == last_a) begin
							iss_q   <= 1'b0;
							cnt_q   <= cnt_q - CW'(1);
							res_q   <= '{status: ST_REMOVED,
									position: POSITION_W'(addr_s1),
									occupancy: OCCUPANCY_W'(cnt_q - CW'(1))};
							state_q <= S_DONE;
						end else begin
							// Pull the entries behind the match up by one.
							rd_q    <= addr_s1 + AW'(1);
							end_q   <= last_a;
							up_q    <= 1'b1;
							iss_q   <= 1'b1;
							state_q <= S_SHIFT;
						end
					end else if (vld_s1 && addr_s1 == last_a) begin
						iss_q  <= 1'b0;
						vld_s1 <= 1'b0;
						if (op_q == OP_INSERT) begin
							pos_q   <= AW'(cnt_q);
							state_q <= S_PUT;
						end else begin
							res_q   <= '{status: ST_NOT_FOUND, position: '0,
									occupancy: OCCUPANCY_W'(cnt_q)};
							state_q <= S_DONE;
						end
					end
				end
				S_SHIFT: begin
					if (iss_q) begin
						if (rd_q == end_q) begin
							iss_q <= 1'b0;
						end else begin
							rd_q <= up_q ? (rd_q + AW'(1)) : (rd_q - AW'(1));
						end
					end
					if (vld_s1 && !iss_q) begin
						if (op_q == OP_INSERT) begin
							state_q <= S_PUT;
						end else begin
							cnt_q   <= cnt_q - CW'(1);
							res_q   <= '{status: ST_REMOVED,
									position: POSITION_W'(pos_q),
									occupancy: OCCUPANCY_W'(cnt_q - CW'(1))};
							state_q <= S_DONE;
						end
					end
				end
				S_PUT: begin
					cnt_q   <= cnt_q + CW'(1);
					res_q   <= '{status: ST_INSERTED, position: POSITION_W'(pos_q),
							occupancy: OCCUPANCY_W'(cnt_q + CW'(1))};
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/three_level_priority_queue_top.sv
// Top level of the three-level priority queue: request channel, core and result register.
`timescale 1ns / 1ps
//
// The block holds an ordered table of up to DEPTH entries, each an id and a
// class (red, yellow, green or class three). A request on the in channel either inserts an
// entry ahead of the first stored entry of a worse class or removes the first
// entry whose id matches. Each request yields exactly one result on the out
// channel: status, position used and the number of entries held afterward.
// Both channels use valid and ready; a transfer happens when both are high.
// One request is worked on at a time, with one read and one write of the
// table memory per cycle. With n entries stored, the scan reads entries until
// it finds the position and the shift then moves the entries behind it. An
// insert then writes the new entry, and the result goes to the output
// register. The next request can be taken in the same cycle that the result
// appears there. A full-table insert or a remove on an empty table skips the
// scan and goes straight to the result.
// The output register lets the next request be taken while a result waits;
// if the receiver stalls, the block finishes that request and then holds.
// Reset empties the table (count to zero) and clears both valid flags.
module three_level_priority_queue_top import tlpq_pkg::*; #(
	parameter int DEPTH   = DEPTH_DEF,
	parameter int ID_BITS = ID_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  tlpq_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output tlpq_out_t out_data
);

	tlpq_res_t res;
	logic      res_take;
	logic      out_valid_q;
	tlpq_out_t out_q;

	assign res_take  = res.valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	tlpq_core #(
		.DEPTH   (DEPTH),
		.ID_BITS (ID_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_ready (in_ready),
		.req_data  (in_data),
		.res       (res),
		.res_take  (res_take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
			out_q       <= res.result;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: hdl/tlpq_checker.sv
// Port-level checks on the three-level priority queue, bound to the top level.
`timescale 1ns / 1ps

module tlpq_checker import tlpq_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input tlpq_in_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input tlpq_out_t out_data
);

	// A stalled result must hold until the receiver takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// The engine works on one request at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in progress");

	// A new result appears only when the engine finishes, never while it idles.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a finished request");

	// Failed operations report position zero.
	a_fail_position: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_FULL || out_data.status == ST_NOT_FOUND)
		|-> out_data.position == '0)
		else $error("failed operation reports a nonzero position");

endmodule

bind three_level_priority_queue_top tlpq_checker u_tlpq_checker (.*);

// File: dv/three_level_priority_queue_top_tb.sv
// Self-checking testbench for the three-level priority queue top level.
`timescale 1ns / 1ps

module three_level_priority_queue_top_tb;
	import tlpq_pkg::*;

	localparam int TABLE_DEPTH = DEPTH_DEF;
	localparam int HOLD_CYCLES = 400;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	tlpq_in_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	tlpq_out_t out_data;

	// Shadow copy of the queue table, kept in step with accepted requests.
	logic [ENTRY_ID_W-1:0] shadow_id [TABLE_DEPTH];
	logic [CLASS_W-1:0]    shadow_cls [TABLE_DEPTH];
	int                    shadow_len = 0;

	tlpq_out_t outcome_fifo [$];
	int        mismatch_count = 0;
	bit        calm = 1'b0;
	bit        hold_req = 1'b0;
	int        stall_left = 0;

	three_level_priority_queue_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic apply_request(input tlpq_in_t req, output tlpq_out_t res);
		int  pos;
		int  i;
		bit  hit;
		pos = 0;
		hit = 1'b0;
		res = '0;
		if (req.op == OP_INSERT) begin
			if (shadow_len >= TABLE_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				pos = shadow_len;
				for (i = 0; i < shadow_len; i++) begin
					// Class three is never passed by a new entry.
					if (!hit && shadow_cls[i] <= CLASS_GREEN &&
							req.priority_class < shadow_cls[i]) begin
						pos = i;
						hit = 1'b1;
					end
				end
				for (i = shadow_len; i > pos; i--) begin
					shadow_id[i]  = shadow_id[i-1];
					shadow_cls[i] = shadow_cls[i-1];
				end
				shadow_id[pos]  = req.entry_id;
				shadow_cls[pos] = req.priority_class;
				shadow_len++;
				res.status   = ST_INSERTED;
				res.position = POSITION_W'(pos);
			end
		end else begin
			for (i = 0; i < shadow_len; i++) begin
				if (!hit && shadow_id[i] == req.entry_id) begin
					pos = i;
					hit = 1'b1;
				end
			end
			if (!hit) begin
				res.status = ST_NOT_FOUND;
			end else begin
				for (i = pos; i + 1 < shadow_len; i++) begin
					shadow_id[i]  = shadow_id[i+1];
					shadow_cls[i] = shadow_cls[i+1];
				end
				shadow_len--;
				res.status   = ST_REMOVED;
				res.position = POSITION_W'(pos);
			end
		end
		res.occupancy = OCCUPANCY_W'(shadow_len);
	endtask

	// Offers one request and returns at the edge where it is taken.
	task automatic send_request(input logic op, input logic [ENTRY_ID_W-1:0] id,
			input logic [CLASS_W-1:0] cls);
		tlpq_in_t  req;
		tlpq_out_t res;
		req.op             = op;
		req.entry_id       = id;
		req.priority_class = cls;
		while (!calm && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		apply_request(req, res);
		outcome_fifo.push_back(res);
	endtask

	task automatic check_result(input tlpq_out_t got);
		tlpq_out_t want;
		if (outcome_fifo.size() == 0) begin
			$error("unexpected result: status %0d position %0d occupancy %0d",
				got.status, got.position, got.occupancy);
			mismatch_count++;
		end else begin
			want = outcome_fifo.pop_front();
			if (got.status !== want.status) begin
				$error("status mismatch: expected %0d, actual %0d", want.status, got.status);
				mismatch_count++;
			end
			if (got.position !== want.position) begin
				$error("position mismatch: expected %0d, actual %0d",
					want.position, got.position);
				mismatch_count++;
			end
			if (got.occupancy !== want.occupancy) begin
				$error("occupancy mismatch: expected %0d, actual %0d",
					want.occupancy, got.occupancy);
				mismatch_count++;
			end
		end
	endtask

	// Result side: checks every accepted result and decides ready for the next cycle.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				check_result(out_data);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
				out_ready  <= 1'b0;
			end else begin
				out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
			end
		end
	end

	// Empty-table remove, both id extremes, every class, duplicates and misses.
	task automatic test_basic_cases();
		send_request(OP_REMOVE, 16'h0000, CLASS_RED);
		send_request(OP_INSERT, 16'hFFFF, CLASS_GREEN);
		send_request(OP_INSERT, 16'h0000, CLASS_YELLOW);
		send_request(OP_INSERT, 16'h1234, CLASS_RED);
		send_request(OP_INSERT, 16'hABCD, 2'd3);
		send_request(OP_INSERT, 16'h1234, CLASS_RED);
		send_request(OP_INSERT, 16'h5555, CLASS_GREEN);
		send_request(OP_REMOVE, 16'h1234, 2'd3);
		send_request(OP_REMOVE, 16'h9999, CLASS_RED);
		send_request(OP_REMOVE, 16'hFFFF, CLASS_GREEN);
	endtask

	// Fills the table, tries one insert too many, then removes the class-three entry ABCD.
	task automatic test_fill_to_full();
		int k;
		for (k = 0; k < 12; k++)
			send_request(OP_INSERT, 16'(16'h0F00 + k), CLASS_W'(k % 4));
		send_request(OP_INSERT, 16'h7777, CLASS_RED);
		send_request(OP_REMOVE, 16'hABCD, CLASS_RED);
	endtask

	task automatic random_request(input int insert_pct);
		logic [ENTRY_ID_W-1:0] id;
		logic [CLASS_W-1:0]    cls;
		int                    pick;
		pick = $urandom_range(99);
		if (pick < 30)
			cls = CLASS_RED;
		else if (pick < 60)
			cls = CLASS_YELLOW;
		else if (pick < 90)
			cls = CLASS_GREEN;
		else
			cls = 2'd3;
		// A small id pool makes duplicates common.
		if ($urandom_range(99) < 40)
			id = ENTRY_ID_W'($urandom_range(7));
		else
			id = ENTRY_ID_W'($urandom_range(16'hFFFF));
		if ($urandom_range(99) < insert_pct) begin
			send_request(OP_INSERT, id, cls);
		end else begin
			// Most removes target an id that is actually stored.
			if (shadow_len > 0 && $urandom_range(99) < 75)
				id = shadow_id[$urandom_range(shadow_len - 1)];
			send_request(OP_REMOVE, id, cls);
		end
	endtask

	task automatic test_random_traffic(input int count, input int insert_pct);
		int k;
		for (k = 0; k < count; k++)
			random_request(insert_pct);
	endtask

	// The receiver stops for a long while; the sender keeps pushing until the input stalls.
	task automatic test_output_stall(input int count);
		hold_req = 1'b1;
		test_random_traffic(count, 60);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_cases();
		test_fill_to_full();
		test_random_traffic(300, 75);
		test_random_traffic(300, 25);
		calm = 1'b1;
		test_random_traffic(300, 50);
		calm = 1'b0;
		test_output_stall(30);
		test_random_traffic(300, 85);
		test_random_traffic(300, 15);
		test_random_traffic(270, 50);
		in_valid <= 1'b0;
		while (outcome_fifo.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#6_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
